@@ sv/pst_pkg.sv @@
// Shared types and constants for the position slot table.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package pst_pkg;

    localparam int SLOTS = 256;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NUM_W = $clog2(SLOTS + 1);
    localparam int RADIUS_MAX = 64;
    localparam int COUNT_MAX = 511;

    localparam logic [2:0] OP_LOOKUP = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_UNLOAD = 3'd2;
    localparam logic [2:0] OP_EVICT = 3'd3;
    localparam logic [2:0] OP_COUNT = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EXISTS = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOT_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIUS = 1'd1;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } pst_req_t;

    typedef struct packed {
        logic [7:0] slot;
        logic [1:0] status;
        logic [8:0] count;
    } pst_rsp_t;

    typedef struct packed {
        logic        loaded;
        logic [15:0] pos_y;
        logic [15:0] pos_x;
    } pst_entry_t;

    typedef struct packed {
        logic [NUM_W-1:0] slots;
        logic [6:0]       radius;
    } pst_cfg_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } pst_rd_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        pst_entry_t       entry;
    } pst_wr_t;

endpackage

`default_nettype wire

@@ sv/pst_req_if.sv @@
// Request channel: valid/ready handshake carrying one table operation.
// Depends on pst_pkg for the payload type.
`default_nettype none

interface pst_req_if;
    logic              valid;
    logic              ready;
    pst_pkg::pst_req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/pst_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one operation result.
// Depends on pst_pkg for the payload type.
`default_nettype none

interface pst_rsp_if;
    logic              valid;
    logic              ready;
    pst_pkg::pst_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/position_slot_table_unit.sv @@
// Position slot table: lookup, insert, unload, evict-far and count over a slot store.
// Each valid operation scans the slots in use one per cycle and the unit takes no new
// request until its result is registered; lookup, insert and unload stop at the first
// matching slot. Scan rate is set by the single store read port. The result is loaded
// into the output register from the done state once any previous response is taken.
// Reset clears all slots to position (0,0) unloaded, slot_count to 81, radius to 4.
`default_nettype none

module position_slot_table_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [pst_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [8:0]                           cfg_wdata,
    pst_req_if.sink                                   req,
    pst_rsp_if.source                                 rsp
);

    logic [8:0]          slot_count_reg;
    logic [6:0]          radius_reg;
    pst_pkg::pst_cfg_t   cfg;
    pst_pkg::pst_rd_t    rd;
    pst_pkg::pst_wr_t    wr;
    pst_pkg::pst_entry_t rd_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= 9'd81;
            radius_reg     <= 7'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pst_pkg::REG_SLOT_COUNT: slot_count_reg <= cfg_wdata;
                pst_pkg::REG_RADIUS:     radius_reg     <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (slot_count_reg == 9'd0)
        begin
            cfg.slots = pst_pkg::NUM_W'(1);
        end
        else if (32'(slot_count_reg) > 32'(pst_pkg::SLOTS))
        begin
            cfg.slots = pst_pkg::NUM_W'(pst_pkg::SLOTS);
        end
        else
        begin
            cfg.slots = pst_pkg::NUM_W'(slot_count_reg);
        end

        if (radius_reg == 7'd0)
        begin
            cfg.radius = 7'd1;
        end
        else if (radius_reg > 7'(pst_pkg::RADIUS_MAX))
        begin
            cfg.radius = 7'(pst_pkg::RADIUS_MAX);
        end
        else
        begin
            cfg.radius = radius_reg;
        end
    end

    pst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .req      (req),
        .rsp      (rsp),
        .rd       (rd),
        .rd_entry (rd_entry),
        .wr       (wr)
    );

    pst_mem u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd       (rd),
        .wr       (wr),
        .rd_entry (rd_entry)
    );

endmodule

`default_nettype wire

@@ sv/pst_mem.sv @@
// Slot store: one write port, one registered read port, per-entry written flags
// so that never-written entries read as position (0,0), unloaded. Uses pst_pkg.
`default_nettype none

module pst_mem (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pst_pkg::pst_rd_t    rd,
    input  wire pst_pkg::pst_wr_t    wr,
    output pst_pkg::pst_entry_t      rd_entry
);

    pst_pkg::pst_entry_t        mem_array [pst_pkg::SLOTS];
    pst_pkg::pst_entry_t        q_reg;
    logic                       q_valid_reg;
    logic [pst_pkg::SLOTS-1:0]  written_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_array[wr.addr] <= wr.entry;
        end
        if (rd.en)
        begin
            q_reg <= mem_array[rd.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                written_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                q_valid_reg <= written_reg[rd.addr];
            end
        end
    end

    assign rd_entry = q_valid_reg ? q_reg : '0;

endmodule

`default_nettype wire

@@ sv/pst_ctrl.sv @@
// Scan sequencer: walks the slots in use one per cycle through pst_mem,
// modifies and writes back entries, and holds the result register. Uses pst_pkg.
`default_nettype none

module pst_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pst_pkg::pst_cfg_t   cfg,
    pst_req_if.sink                  req,
    pst_rsp_if.source                rsp,
    output pst_pkg::pst_rd_t         rd,
    input  wire pst_pkg::pst_entry_t rd_entry,
    output pst_pkg::pst_wr_t         wr
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    logic [2:0]                   op_reg, op_next;
    logic [15:0]                  key_x_reg, key_x_next;
    logic [15:0]                  key_y_reg, key_y_next;
    logic [pst_pkg::NUM_W-1:0]    slots_reg, slots_next;
    logic [6:0]                   radius_reg, radius_next;
    logic [pst_pkg::NUM_W-1:0]    idx_reg, idx_next;
    logic [pst_pkg::IDX_W-1:0]    didx_reg, didx_next;
    logic                         pend_reg, pend_next;
    logic                         free_found_reg, free_found_next;
    logic [pst_pkg::IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [pst_pkg::NUM_W-1:0]    count_reg, count_next;
    logic [7:0]                   slot_reg, slot_next;
    logic [1:0]                   status_reg, status_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    pst_pkg::pst_rsp_t            rsp_data_reg, rsp_data_next;

    logic                         issue;
    logic                         proc;
    logic                         match;
    logic                         last;
    logic                         far;
    logic signed [16:0]           dx, dy;
    logic [16:0]                  adx, ady;
    logic [pst_pkg::IDX_W-1:0]    target;
    logic [8:0]                   count_out;

    assign issue = (state_reg == S_SCAN) && (idx_reg < slots_reg);
    assign proc  = (state_reg == S_SCAN) && pend_reg;
    assign match = (rd_entry.pos_x == key_x_reg) && (rd_entry.pos_y == key_y_reg);
    assign last  = (pst_pkg::NUM_W'(didx_reg) == (slots_reg - pst_pkg::NUM_W'(1)));

    assign dx  = $signed({key_x_reg[15], key_x_reg})
               - $signed({rd_entry.pos_x[15], rd_entry.pos_x});
    assign dy  = $signed({key_y_reg[15], key_y_reg})
               - $signed({rd_entry.pos_y[15], rd_entry.pos_y});
    assign adx = dx[16] ? 17'(-dx) : 17'(dx);
    assign ady = dy[16] ? 17'(-dy) : 17'(dy);
    assign far = (adx > {10'd0, radius_reg}) || (ady > {10'd0, radius_reg});

    assign count_out = (32'(count_reg) > 32'(pst_pkg::COUNT_MAX))
                     ? 9'(pst_pkg::COUNT_MAX) : 9'(count_reg);

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    assign rd.en   = issue;
    assign rd.addr = idx_reg[pst_pkg::IDX_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_x_next      = key_x_reg;
        key_y_next      = key_y_reg;
        slots_next      = slots_reg;
        radius_next     = radius_reg;
        idx_next        = idx_reg;
        didx_next       = didx_reg;
        pend_next       = pend_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        count_next      = count_reg;
        slot_next       = slot_reg;
        status_next     = status_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_data_next   = rsp_data_reg;
        wr              = '0;
        target          = '0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next         = req.data.op;
                    key_x_next      = req.data.pos_x;
                    key_y_next      = req.data.pos_y;
                    slots_next      = cfg.slots;
                    radius_next     = cfg.radius;
                    idx_next        = '0;
                    pend_next       = 1'b0;
                    free_found_next = 1'b0;
                    count_next      = '0;
                    slot_next       = '0;
                    status_next     = pst_pkg::ST_OK;
                    if (req.data.op > pst_pkg::OP_COUNT)
                    begin
                        status_next = pst_pkg::ST_MISS;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                pend_next = issue;
                didx_next = idx_reg[pst_pkg::IDX_W-1:0];
                if (issue)
                begin
                    idx_next = idx_reg + pst_pkg::NUM_W'(1);
                end
                if (proc)
                begin
                    case (op_reg)
                        pst_pkg::OP_LOOKUP:
                        begin
                            if (match)
                            begin
                                state_next = S_DONE;
                                if (rd_entry.loaded)
                                begin
                                    slot_next = 8'(didx_reg);
                                end
                                else
                                begin
                                    status_next = pst_pkg::ST_MISS;
                                end
                            end
                            else if (last)
                            begin
                                status_next = pst_pkg::ST_MISS;
                                state_next  = S_DONE;
                            end
                        end
                        pst_pkg::OP_INSERT:
                        begin
                            if (match && rd_entry.loaded)
                            begin
                                slot_next   = 8'(didx_reg);
                                status_next = pst_pkg::ST_EXISTS;
                                state_next  = S_DONE;
                            end
                            else if (match || last)
                            begin
                                if (free_found_reg)
                                begin
                                    target = free_idx_reg;
                                end
                                else if (!rd_entry.loaded)
                                begin
                                    target = didx_reg;
                                end
                                wr.en           = 1'b1;
                                wr.addr         = target;
                                wr.entry.loaded = 1'b1;
                                wr.entry.pos_x  = key_x_reg;
                                wr.entry.pos_y  = key_y_reg;
                                slot_next       = 8'(target);
                                state_next      = S_DONE;
                            end
                            else if (!rd_entry.loaded && !free_found_reg)
                            begin
                                free_found_next = 1'b1;
                                free_idx_next   = didx_reg;
                            end
                        end
                        pst_pkg::OP_UNLOAD:
                        begin
                            if (match)
                            begin
                                state_next = S_DONE;
                                if (rd_entry.loaded)
                                begin
                                    wr.en           = 1'b1;
                                    wr.addr         = didx_reg;
                                    wr.entry        = rd_entry;
                                    wr.entry.loaded = 1'b0;
                                    slot_next       = 8'(didx_reg);
                                end
                                else
                                begin
                                    status_next = pst_pkg::ST_MISS;
                                end
                            end
                            else if (last)
                            begin
                                status_next = pst_pkg::ST_MISS;
                                state_next  = S_DONE;
                            end
                        end
                        pst_pkg::OP_EVICT:
                        begin
                            if (rd_entry.loaded && far)
                            begin
                                wr.en           = 1'b1;
                                wr.addr         = didx_reg;
                                wr.entry        = rd_entry;
                                wr.entry.loaded = 1'b0;
                                count_next      = count_reg + pst_pkg::NUM_W'(1);
                            end
                            if (last)
                            begin
                                state_next = S_DONE;
                            end
                        end
                        pst_pkg::OP_COUNT:
                        begin
                            if (rd_entry.loaded)
                            begin
                                count_next = count_reg + pst_pkg::NUM_W'(1);
                            end
                            if (last)
                            begin
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_data_next.slot   = slot_reg;
                    rsp_data_next.status = status_reg;
                    rsp_data_next.count  = count_out;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_x_reg      <= key_x_next;
        key_y_reg      <= key_y_next;
        slots_reg      <= slots_next;
        radius_reg     <= radius_next;
        didx_reg       <= didx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        count_reg      <= count_next;
        slot_reg       <= slot_next;
        status_reg     <= status_next;
        rsp_data_reg   <= rsp_data_next;
    end

    a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> state_reg == S_SCAN)
        else $error("table write outside a scan");

    a_exists_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_data_reg.status == pst_pkg::ST_EXISTS)
            |-> rsp_data_reg.count == '0)
        else $error("insert refusal carries a count");

    a_done_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |=> state_reg == S_IDLE || state_reg == S_DONE)
        else $error("result stage left for a scan");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> count_reg <= slots_reg)
        else $error("count exceeds slots in use");

endmodule

`default_nettype wire
